/* rtl/crc16fr_pkg.sv */
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared constants, codes and the CRC-16-CCITT byte update for the frame
// receiver.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

    localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd170;
    localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RST = 16'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_START_BYTE    = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    // tuser codes
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((r & CRC_MSB) != '0)
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[CRC_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* rtl/crc16_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Framed packet receiver: start byte, 16-bit LE length, sequence, command,
// payload, 16-bit LE CRC-16-CCITT (0x1021, init 0xFFFF) over seq/cmd/payload.
//
// Usage:
//   s_axis carries one received byte per word. m_axis gives one word per
//   payload byte (tuser = 0) and one verdict word after the last CRC byte
//   (tuser = 1, crc_good set when the CRC matched). Headers, oversized frames
//   (length above payload_limit) and bytes seen while hunting give no word.
//   An APB port holds start_byte (0x0) and payload_limit (0x4).
//   Throughput: one byte per cycle while m_axis does not stall; the input
//   register, the frame state and the output register each advance once per
//   cycle, the CRC byte update is combinational logic feeding the CRC register.
//   When m_axis stalls, the output register holds its word and one more byte
//   waits in the input register; s_axis_tready then drops.
//   Reset puts the block in the hunting state with empty registers and the
//   configuration back at start_byte = 170, payload_limit = 1024.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
    import crc16fr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] payload_byte, [15:8] frame_seq, [23:16] frame_cmd,
    // [39:24] frame_len, [40] crc_good, [47:41] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,  // [0] result_kind
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        PH_SOF,
        PH_LEN0,
        PH_LEN1,
        PH_SEQ,
        PH_CMD,
        PH_PAY,
        PH_CRC0,
        PH_CRC1
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]   seq_reg, seq_next;
    logic [BYTE_W-1:0]   cmd_reg, cmd_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [BYTE_W-1:0]   crc_low_reg, crc_low_next;
    logic [BYTE_W-1:0]   start_byte_reg, start_byte_next;
    logic [LEN_W-1:0]    limit_reg, limit_next;
    logic                in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]   in_byte_reg, in_byte_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    logic                out_free;
    logic                proc;
    logic                s_accept;
    logic                cfg_write;
    logic                res_valid;
    logic                res_kind;
    logic [BYTE_W-1:0]   res_byte;
    logic                res_good;
    logic [CRC_W-1:0]    crc_upd;
    logic [LEN_W-1:0]    count_inc;
    logic [LEN_W-1:0]    len_full;
    logic [CRC_W-1:0]    crc_rx;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_write     = psel && penable && pwrite;

    assign crc_upd   = crc_byte(crc_reg, in_byte_reg);
    assign count_inc = count_reg + 1'b1;
    assign len_full  = {in_byte_reg, len_reg[BYTE_W-1:0]};
    assign crc_rx    = {in_byte_reg, crc_low_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        len_next        = len_reg;
        count_next      = count_reg;
        seq_next        = seq_reg;
        cmd_next        = cmd_reg;
        crc_next        = crc_reg;
        crc_low_next    = crc_low_reg;
        start_byte_next = start_byte_reg;
        limit_next      = limit_reg;
        res_valid       = 1'b0;
        res_kind        = KIND_PAYLOAD;
        res_byte        = '0;
        res_good        = 1'b0;

        if (cfg_write)
        begin
            case (paddr[2])
                REG_START_BYTE:    start_byte_next = pwdata[BYTE_W-1:0];
                REG_PAYLOAD_LIMIT: limit_next      = pwdata[LEN_W-1:0];
                default:           ;
            endcase
        end

        if (proc)
        begin
            case (phase_reg)
                PH_SOF:
                begin
                    if (in_byte_reg == start_byte_reg)
                        phase_next = PH_LEN0;
                end
                PH_LEN0:
                begin
                    len_next   = {{(LEN_W-BYTE_W){1'b0}}, in_byte_reg};
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_next   = len_full;
                    phase_next = (len_full > limit_reg) ? PH_SOF : PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_next   = in_byte_reg;
                    crc_next   = crc_byte(CRC_INIT, in_byte_reg);
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = in_byte_reg;
                    crc_next   = crc_upd;
                    count_next = '0;
                    phase_next = (len_reg != '0) ? PH_PAY : PH_CRC0;
                end
                PH_PAY:
                begin
                    crc_next   = crc_upd;
                    count_next = count_inc;
                    if (count_inc >= len_reg)
                        phase_next = PH_CRC0;
                    res_valid  = 1'b1;
                    res_kind   = KIND_PAYLOAD;
                    res_byte   = in_byte_reg;
                end
                PH_CRC0:
                begin
                    crc_low_next = in_byte_reg;
                    phase_next   = PH_CRC1;
                end
                PH_CRC1:
                begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_VERDICT;
                    res_good   = (crc_rx == crc_reg);
                    phase_next = PH_SOF;
                end
                default:
                    phase_next = PH_SOF;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_axis_tdata;
        end
        else if (proc)
            in_valid_next = 1'b0;

        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (proc && res_valid)
        begin
            m_valid_next = 1'b1;
            m_user_next  = res_kind;
            m_data_next  = {7'b0, res_good, len_reg, cmd_next, seq_reg, res_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SOF;
            len_reg        <= '0;
            count_reg      <= '0;
            seq_reg        <= '0;
            cmd_reg        <= '0;
            crc_reg        <= CRC_INIT;
            crc_low_reg    <= '0;
            start_byte_reg <= START_BYTE_RST;
            limit_reg      <= PAYLOAD_LIMIT_RST;
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= KIND_PAYLOAD;
        end
        else
        begin
            phase_reg      <= phase_next;
            len_reg        <= len_next;
            count_reg      <= count_next;
            seq_reg        <= seq_next;
            cmd_reg        <= cmd_next;
            crc_reg        <= crc_next;
            crc_low_reg    <= crc_low_next;
            start_byte_reg <= start_byte_next;
            limit_reg      <= limit_next;
            in_valid_reg   <= in_valid_next;
            in_byte_reg    <= in_byte_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
            m_user_reg     <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_PAYLOAD_LIMIT)
                         ? {{(APB_DATA_W-LEN_W){1'b0}}, limit_reg}
                         : {{(APB_DATA_W-BYTE_W){1'b0}}, start_byte_reg};

    a_pay_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (len_reg != '0))
        else $error("payload phase with zero length");

    a_pay_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (count_reg < len_reg))
        else $error("payload count overran length");

    a_pay_word: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && phase_reg == PH_PAY)
        |=> (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD))
        else $error("payload byte did not produce a payload word");

    a_verdict_word: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && phase_reg == PH_CRC1)
        |=> (m_axis_tvalid && m_axis_tuser == KIND_VERDICT && phase_reg == PH_SOF))
        else $error("last CRC byte did not produce a verdict");

    a_no_word_header: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && phase_reg != PH_PAY && phase_reg != PH_CRC1)
        |=> !$rose(m_axis_tvalid))
        else $error("word produced outside payload or verdict");

endmodule

/* test/tb_crc16_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver
// Self-checking bench for the CRC-16 frame receiver. Byte streams of well
// formed, corrupted, truncated and oversized frames mixed with line noise are
// pushed through s_axis under random bursts and gaps, while m_axis stalls on
// its own schedule. A frame tracker in the bench predicts every payload and
// verdict word, and the monitor checks each word field by field. APB writes
// change the start byte and the length limit between traffic phases.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver;
    import crc16fr_pkg::*;

    localparam int          CLK_PERIOD = 12;
    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam logic [15:0] CCITT_SEED = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_HUNT, ST_LEN_LO, ST_LEN_HI, ST_SEQ, ST_CMD, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
    } rx_phase_t;

    typedef struct {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  seq;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic        good;
    } frame_word_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // bench copy of the configuration and frame state
    logic [7:0]  cfg_start = START_BYTE_RST;
    logic [15:0] cfg_limit = PAYLOAD_LIMIT_RST;
    rx_phase_t   rx_phase  = ST_HUNT;
    logic [15:0] hdr_len   = '0;
    logic [15:0] pay_count = '0;
    logic [7:0]  seq_seen  = '0;
    logic [7:0]  cmd_seen  = '0;
    logic [15:0] crc_acc   = CCITT_SEED;
    logic [7:0]  crc_lo    = '0;

    frame_word_t frame_results[$];
    logic [7:0]  tx_bytes[$];
    logic [7:0]  frame_bytes[$];
    int          queued_bytes = 0;
    int          error_count  = 0;

    bit          sender_gaps  = 1'b1;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          hold_request = 0;
    int          hold_served  = 0;
    int          hold_left    = 0;
    int          mode_left    = 0;
    logic [1:0]  stall_mode   = '0;
    int          pattern_cnt  = 0;

    crc16_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CCITT_POLY;
        end
        return r;
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        frame_word_t w;
        logic        emit;
        w.kind = KIND_PAYLOAD;
        w.data = 8'h00;
        w.good = 1'b0;
        emit   = 1'b0;
        case (rx_phase)
            ST_HUNT:
                if (b == cfg_start)
                    rx_phase = ST_LEN_LO;
            ST_LEN_LO:
            begin
                hdr_len  = {8'h00, b};
                rx_phase = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                hdr_len[15:8] = b;
                rx_phase = (hdr_len > cfg_limit) ? ST_HUNT : ST_SEQ;
            end
            ST_SEQ:
            begin
                seq_seen = b;
                crc_acc  = ccitt_update(CCITT_SEED, b);
                rx_phase = ST_CMD;
            end
            ST_CMD:
            begin
                cmd_seen  = b;
                crc_acc   = ccitt_update(crc_acc, b);
                pay_count = '0;
                rx_phase  = (hdr_len != 0) ? ST_PAYLOAD : ST_CRC_LO;
            end
            ST_PAYLOAD:
            begin
                crc_acc   = ccitt_update(crc_acc, b);
                pay_count = pay_count + 16'd1;
                if (pay_count >= hdr_len)
                    rx_phase = ST_CRC_LO;
                w.data = b;
                emit   = 1'b1;
            end
            ST_CRC_LO:
            begin
                crc_lo   = b;
                rx_phase = ST_CRC_HI;
            end
            default:
            begin
                w.kind   = KIND_VERDICT;
                w.good   = ({b, crc_lo} == crc_acc);
                rx_phase = ST_HUNT;
                emit     = 1'b1;
            end
        endcase
        if (emit)
        begin
            w.seq = seq_seen;
            w.cmd = cmd_seen;
            w.len = hdr_len;
            frame_results.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    // sender: bursts of random length with random gaps between them
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tx_bytes.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= sender_gaps ? $urandom_range(0, 8) : 0;
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall modes change at random intervals, long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_request != hold_served)
        begin
            hold_served   <= hold_request;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left  <= $urandom_range(20, 120);
                stall_mode <= 2'($urandom_range(0, 3));
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (pattern_cnt % 3 != 0);
            endcase
            pattern_cnt <= pattern_cnt + 1;
        end
    end

    always @(posedge clk)
    begin
        frame_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_results.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata, '0);
            else
            begin
                want = frame_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("result_kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch("payload_byte", m_axis_tdata[7:0], want.data);
                if (m_axis_tdata[15:8] !== want.seq)
                    report_mismatch("frame_seq", m_axis_tdata[15:8], want.seq);
                if (m_axis_tdata[23:16] !== want.cmd)
                    report_mismatch("frame_cmd", m_axis_tdata[23:16], want.cmd);
                if (m_axis_tdata[39:24] !== want.len)
                    report_mismatch("frame_len", m_axis_tdata[39:24], want.len);
                if (m_axis_tdata[40] !== want.good)
                    report_mismatch("crc_good", m_axis_tdata[40], want.good);
            end
        end
    end

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata);
        logic [31:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (wr)
        begin
            if (idx == REG_START_BYTE)
                cfg_start = wdata[7:0];
            else
                cfg_limit = wdata[15:0];
        end
        else
        begin
            want = (idx == REG_START_BYTE) ? {24'h0, cfg_start} : {16'h0, cfg_limit};
            if (prdata !== want)
                report_mismatch("register readback", prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sof, input logic [15:0] limit);
        logic [31:0] wdata;
        wdata = $urandom();
        wdata[7:0] = sof;
        apb_access(1'b1, REG_START_BYTE, wdata);
        wdata = $urandom();
        wdata[15:0] = limit;
        apb_access(1'b1, REG_PAYLOAD_LIMIT, wdata);
        apb_access(1'b0, REG_START_BYTE, '0);
        apb_access(1'b0, REG_PAYLOAD_LIMIT, '0);
    endtask

    // all bytes taken, all words back, then a short wait for bytes still in flight
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tx_bytes.size() != 0 || s_axis_tvalid || frame_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_frame(input logic [7:0] sof, input int len, input logic [7:0] seq,
                               input logic [7:0] cmd, input int fill, input logic crc_ok);
        logic [15:0] crc;
        logic [7:0]  d;
        frame_bytes.delete();
        frame_bytes.push_back(sof);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(seq);
        frame_bytes.push_back(cmd);
        crc = ccitt_update(ccitt_update(CCITT_SEED, seq), cmd);
        for (int i = 0; i < len; i++)
        begin
            d = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            frame_bytes.push_back(d);
            crc = ccitt_update(crc, d);
        end
        if (!crc_ok)
            crc = crc ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic send_bytes(input int n);
        while (n > 0 && frame_bytes.size() != 0)
        begin
            tx_bytes.push_back(frame_bytes.pop_front());
            queued_bytes++;
            n--;
        end
    endtask

    task automatic random_traffic(input int n_bytes);
        int          stop_at;
        int          pick;
        int          len;
        int          room;
        logic [7:0]  d;
        stop_at = queued_bytes + n_bytes;
        while (queued_bytes < stop_at)
        begin
            pick = $urandom_range(0, 99);
            room = (cfg_limit < 12) ? cfg_limit : 12;
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    d = 8'($urandom_range(0, 255));
                    if (d == cfg_start && $urandom_range(0, 3) != 0)
                        d = d ^ 8'h01;
                    tx_bytes.push_back(d);
                end
            end
            else if (pick < 14 && cfg_limit != 16'hFFFF)
            begin
                len = cfg_limit + 1 + $urandom_range(0, 300);
                if (len > 65535)
                    len = 65535;
                queue_frame(cfg_start, len, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), -1, 1'b1);
                send_bytes(3);
            end
            else if (pick < 19)
            begin
                queue_frame(cfg_start, $urandom_range(0, room), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), -1, 1'b1);
                send_bytes($urandom_range(1, frame_bytes.size() - 1));
            end
            else
            begin
                if (pick < 25)
                    len = (cfg_limit <= 64) ? cfg_limit : $urandom_range(13, 64);
                else
                    len = $urandom_range(0, room);
                queue_frame(cfg_start, len, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), -1, $urandom_range(0, 9) != 0);
                send_bytes(frame_bytes.size());
            end
        end
    endtask

    initial
    begin
        logic [15:0] bound_limit;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        apb_access(1'b0, REG_START_BYTE, '0);
        apb_access(1'b0, REG_PAYLOAD_LIMIT, '0);

        // directed: hunting noise, empty frame, bad CRC, oversized, short payload
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        queue_frame(START_BYTE_RST, 0, 8'h00, 8'hFF, -1, 1'b1);
        send_bytes(frame_bytes.size());
        queue_frame(START_BYTE_RST, 1, 8'hFF, 8'h00, 8'hFF, 1'b0);
        send_bytes(frame_bytes.size());
        queue_frame(START_BYTE_RST, PAYLOAD_LIMIT_RST + 1, 8'h00, 8'h00, -1, 1'b1);
        send_bytes(3);
        queue_frame(START_BYTE_RST, 2, 8'h5A, 8'hA5, 8'h00, 1'b1);
        send_bytes(frame_bytes.size());
        wait_drained();

        random_traffic(280);
        wait_drained();

        set_config(8'h00, 16'h0000);
        random_traffic(160);
        wait_drained();

        sender_gaps = 1'b0;
        set_config(8'hFF, 16'hFFFF);
        queue_frame(8'hFF, 300, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    -1, 1'b1);
        send_bytes(frame_bytes.size());
        random_traffic(220);
        wait_drained();

        sender_gaps = 1'b1;
        bound_limit = 16'($urandom_range(8, 40));
        set_config(8'($urandom_range(0, 255)), bound_limit);
        queue_frame(cfg_start, bound_limit, 8'h12, 8'h34, -1, 1'b1);
        send_bytes(frame_bytes.size());
        queue_frame(cfg_start, bound_limit + 1, 8'h56, 8'h78, -1, 1'b1);
        send_bytes(3);
        random_traffic(280);
        wait_drained();

        // limit lowered between the two length bytes, then lowered to zero after the length check
        set_config(START_BYTE_RST, PAYLOAD_LIMIT_RST);
        queue_frame(cfg_start, 20, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    -1, 1'b1);
        send_bytes(2);
        wait_drained();
        set_config(8'h3C, 16'd10);
        send_bytes(frame_bytes.size());
        wait_drained();
        queue_frame(8'h3C, 5, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    -1, 1'b1);
        send_bytes(3);
        wait_drained();
        set_config(8'h11, 16'd0);
        send_bytes(frame_bytes.size());
        wait_drained();

        set_config(8'($urandom_range(0, 255)), 16'($urandom_range(16, 2000)));
        sender_gaps = 1'b0;
        hold_request++;
        random_traffic(250);
        wait_drained();

        sender_gaps = 1'b1;
        set_config(START_BYTE_RST, PAYLOAD_LIMIT_RST);
        random_traffic(160);
        wait_drained();

        if (error_count == 0 && frame_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("simulation failed");
        $finish;
    end

endmodule
